// File: design/idt_pkg.sv
// Shared types and constants for the indentation tracker.
`default_nettype none
package idt_pkg;

    localparam int unsigned MaxDepthDefault = 32;
    localparam logic [3:0]  TabWidthReset   = 4'd4;
    localparam logic [15:0] LineMax         = 16'hFFFF;

    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;

    typedef enum logic [1:0] {
        KIND_INDENT = 2'd0,
        KIND_DEDENT = 2'd1,
        KIND_EOF    = 2'd2,
        KIND_CHAR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INCONS  = 2'd1,
        ERR_DEPTH   = 2'd2,
        ERR_UNUSED  = 2'd3
    } t_err;

    // controller -> datapath
    typedef struct packed {
        logic  accept;      // latch input char
        logic  col_space;   // add one column
        logic  col_tab;     // add tab_width columns
        logic  col_clear;
        logic  line_bump;
        logic  ls_set;
        logic  ls_clr;
        logic  push;        // write column at top+1, advance top
        logic  pop;         // step top down
        logic  top_load;    // take top value from stack read
        logic  top_clear;   // top value back to base level
        logic  emit;        // load output register
        t_kind kind;
        t_err  err;
        logic  last;
        logic  char_in;     // emit char straight from input port
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic eoi;
        logic is_space;
        logic is_tab;
        logic is_lf;
        logic is_cr;
        logic at_ls;
        logic col_gt;
        logic col_lt;
        logic top_nz;
        logic top_full;
    } t_sts;

endpackage
`default_nettype wire

// File: design/idt_dp.sv
// Datapath: indent stack memory, counters and output register.
`default_nettype none
module idt_dp
    import idt_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = MaxDepthDefault
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_data,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_end_of_input,
    input  wire logic       i_out_ready,
    input  wire t_cmd       i_cmd,
    output t_sts            o_sts,
    output logic            o_out_valid,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_char_out,
    output logic [15:0]     o_line_number,
    output logic [1:0]      o_error_code,
    output logic            o_last
);

    localparam int unsigned TW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [TW:0] TopMax = (TW + 1)'(MAX_DEPTH - 1);

    logic [7:0]    r_mem [MAX_DEPTH];
    logic [7:0]    r_rd;
    logic          r_rd_zero;

    logic [TW-1:0] r_top, n_top;
    logic [7:0]    r_top_val, n_top_val;
    logic [7:0]    r_col, n_col;
    logic [15:0]   r_line, n_line;
    logic          r_at_ls, n_at_ls;
    logic [3:0]    r_tab;
    logic [7:0]    r_char;
    logic          r_out_valid;
    logic [8:0]    col_sum;
    logic [7:0]    emit_char;

    // stack memory: read always tracks the entry under the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_top + 1'b1] <= r_col;
        end
        r_rd      <= r_mem[r_top - 1'b1];
        r_rd_zero <= (r_top == TW'(1));
    end

    always_comb begin
        col_sum = {1'b0, r_col};
        if (i_cmd.col_space) begin
            col_sum = {1'b0, r_col} + 9'd1;
        end else if (i_cmd.col_tab) begin
            col_sum = {1'b0, r_col} + {5'd0, r_tab};
        end
        n_col = col_sum[8] ? 8'hFF : col_sum[7:0];
        if (i_cmd.col_clear) begin
            n_col = 8'd0;
        end

        n_line = r_line;
        if (i_cmd.line_bump && (r_line != LineMax)) begin
            n_line = r_line + 16'd1;
        end

        n_at_ls = r_at_ls;
        if (i_cmd.ls_set) begin
            n_at_ls = 1'b1;
        end else if (i_cmd.ls_clr) begin
            n_at_ls = 1'b0;
        end

        n_top     = r_top;
        n_top_val = r_top_val;
        if (i_cmd.push) begin
            n_top     = r_top + 1'b1;
            n_top_val = r_col;
        end else if (i_cmd.pop) begin
            n_top = r_top - 1'b1;
        end
        if (i_cmd.top_load) begin
            n_top_val = r_rd_zero ? 8'd0 : r_rd;
        end else if (i_cmd.top_clear) begin
            n_top_val = 8'd0;
        end

        emit_char = 8'd0;
        if (i_cmd.kind == KIND_CHAR) begin
            emit_char = i_cmd.char_in ? i_char_code : r_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_top_val   <= 8'd0;
            r_col       <= 8'd0;
            r_line      <= 16'd1;
            r_at_ls     <= 1'b1;
            r_tab       <= TabWidthReset;
            r_out_valid <= 1'b0;
        end else begin
            r_top     <= n_top;
            r_top_val <= n_top_val;
            r_col     <= n_col;
            r_line    <= n_line;
            r_at_ls   <= n_at_ls;
            if (i_cfg_we) begin
                r_tab <= i_cfg_data;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_char_code;
        end
        if (i_cmd.emit) begin
            o_kind        <= i_cmd.kind;
            o_char_out    <= emit_char;
            o_line_number <= n_line;
            o_error_code  <= i_cmd.err;
            o_last        <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_sts.out_free = !r_out_valid || i_out_ready;
        o_sts.eoi      = i_end_of_input;
        o_sts.is_space = (i_char_code == ChSpace);
        o_sts.is_tab   = (i_char_code == ChTab);
        o_sts.is_lf    = (i_char_code == ChLf);
        o_sts.is_cr    = (i_char_code == ChCr);
        o_sts.at_ls    = r_at_ls;
        o_sts.col_gt   = (r_col > r_top_val);
        o_sts.col_lt   = (r_col < r_top_val);
        o_sts.top_nz   = (r_top != '0);
        o_sts.top_full = ({1'b0, r_top} == TopMax);
    end

endmodule
`default_nettype wire

// File: design/idt_ctrl.sv
// Controller: sequences indent, dedent runs, characters and end of input.
`default_nettype none
module idt_ctrl
    import idt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_DED  = 5'b00100,
        S_CHR  = 5'b01000,
        S_EOF  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.kind = KIND_CHAR;
        o_cmd.err  = ERR_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.eoi) begin
                        n_state = S_EOF;
                    end else if (i_sts.at_ls) begin
                        if (i_sts.is_space) begin
                            o_cmd.col_space = 1'b1;
                        end else if (i_sts.is_tab) begin
                            o_cmd.col_tab = 1'b1;
                        end else if (i_sts.is_lf) begin
                            o_cmd.line_bump = 1'b1;
                            o_cmd.col_clear = 1'b1;
                        end else if (i_sts.is_cr) begin
                            o_cmd.col_clear = 1'b1;
                        end else if (i_sts.col_gt && !i_sts.top_full) begin
                            o_cmd.push = 1'b1;
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = KIND_INDENT;
                            n_state    = S_CHR;
                        end else if (i_sts.col_lt) begin
                            o_cmd.pop = 1'b1;
                            n_state   = S_READ;
                        end else begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.last      = 1'b1;
                            o_cmd.char_in   = 1'b1;
                            o_cmd.err       = i_sts.col_gt ? ERR_DEPTH : ERR_NONE;
                            o_cmd.col_clear = 1'b1;
                            o_cmd.ls_clr    = 1'b1;
                        end
                    end else begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.last    = 1'b1;
                        o_cmd.char_in = 1'b1;
                        if (i_sts.is_lf) begin
                            o_cmd.line_bump = 1'b1;
                            o_cmd.ls_set    = 1'b1;
                            o_cmd.col_clear = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.top_load = 1'b1;
                n_state        = S_DED;
            end
            S_DED: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_DEDENT;
                    if (i_sts.top_nz && i_sts.col_lt) begin
                        o_cmd.pop = 1'b1;
                        n_state   = S_READ;
                    end else begin
                        o_cmd.err = (i_sts.col_lt || i_sts.col_gt) ? ERR_INCONS : ERR_NONE;
                        n_state   = S_CHR;
                    end
                end
            end
            S_CHR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.last      = 1'b1;
                    o_cmd.col_clear = 1'b1;
                    o_cmd.ls_clr    = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EOF: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.top_nz) begin
                        o_cmd.kind = KIND_DEDENT;
                        o_cmd.pop  = 1'b1;
                    end else begin
                        o_cmd.kind      = KIND_EOF;
                        o_cmd.last      = 1'b1;
                        o_cmd.ls_set    = 1'b1;
                        o_cmd.col_clear = 1'b1;
                        o_cmd.top_clear = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: design/indent_dedent_tracker_unit.sv
// Top level of the offside-rule indentation tracker.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------------
//  in       | i_in_valid / o_in_ready     | i_char_code, i_end_of_input
//  out      | o_out_valid / i_out_ready   | o_kind, o_char_out, o_line_number,
//           |                             | o_error_code, o_last
//  cfg      | i_cfg_we (no wait)          | i_cfg_data (tab width)
//
// Steps: a plain character, a dropped indentation byte or an INDENT-free
// line start is handled as it is accepted; an INDENT line emits INDENT, then
// the character. A dedent run pops one level at a time; each pop waits in a
// state that loads the new top from the registered stack memory read, then a
// DEDENT is emitted; the character follows. End of input emits one DEDENT per open level, then EOF.
// Reset (synchronous, active low) empties the stack, sets the line counter to 1
// and tab width to 4; stack memory needs no clearing pass since entries
// above the top are always written by a push before being read.
// A full output register stalls input acceptance and every emission until it is taken.
`default_nettype none
module indent_dedent_tracker_unit
    import idt_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = MaxDepthDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data,
    // input items
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_end_of_input,
    // result items
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_char_out,
    output logic [15:0]      o_line_number,
    output logic [1:0]       o_error_code,
    output logic             o_last
);

    t_cmd cmd;
    t_sts sts;

    // sequence pushes, pops and emissions
    idt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // hold stack, counters and the output item
    idt_dp #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .i_out_ready    (i_out_ready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_char_out     (o_char_out),
        .o_line_number  (o_line_number),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire
